[hdl/atl_pkg.sv]
// Shared constants, types and the arctangent table for the accelerometer tilt angle block.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package atl_pkg;

   localparam int IN_W          = 16;
   localparam int OFS_W         = 15;
   localparam int OUT_W         = 16;
   localparam int Q12_W         = 15;
   localparam int CORDIC_STAGES = 14;
   localparam int CW            = 35;
   localparam int AW            = 23;
   localparam int IN_SCALE      = 16;
   localparam int RAD_W         = 32;
   localparam int ROOT_W        = 32;
   localparam int REM_W         = ROOT_W + 3;
   localparam int SQRT_STEPS    = ROOT_W;
   localparam int ROUND_SH      = AW - Q12_W;
   localparam int CSR_IDX_W     = 2;

   localparam logic signed [AW-1:0] HALF_PI_Q20 = AW'(1647099);
   localparam logic [AW-1:0]        ROUND_HALF  = AW'(1) << (ROUND_SH - 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROLL_OFFSET   = 2'd0,
      CSR_MIDDLE_OFFSET = 2'd1,
      CSR_TILT_OFFSET   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [IN_W-1:0] x;
      logic signed [IN_W-1:0] y;
      logic signed [IN_W-1:0] z;
   } sample_type;

   function automatic logic signed [CW-1:0] scale_in(input logic signed [IN_W-1:0] v);
      logic signed [CW-1:0] ext;
      ext = CW'(v);
      return ext <<< IN_SCALE;
   endfunction

   function automatic logic signed [AW-1:0] atan_q20(input int idx);
      logic signed [AW-1:0] t;
      case (idx)
         0:       t = AW'(823550);
         1:       t = AW'(486170);
         2:       t = AW'(256879);
         3:       t = AW'(130396);
         4:       t = AW'(65451);
         5:       t = AW'(32757);
         6:       t = AW'(16383);
         7:       t = AW'(8192);
         8:       t = AW'(4096);
         9:       t = AW'(2048);
         10:      t = AW'(1024);
         11:      t = AW'(512);
         12:      t = AW'(256);
         13:      t = AW'(128);
         14:      t = AW'(64);
         15:      t = AW'(32);
         16:      t = AW'(16);
         17:      t = AW'(8);
         18:      t = AW'(4);
         19:      t = AW'(2);
         20:      t = AW'(1);
         default: t = '0;
      endcase
      return t;
   endfunction

endpackage

`default_nettype wire

[hdl/atl_isqrt.sv]
// Pipelined integer square root, one result bit per stage, with the sample carried alongside.
// Depends on atl_pkg.
`default_nettype none

module atl_isqrt import atl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  logic [RAD_W-1:0]  in_rad,
   input  sample_type        in_smp,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output sample_type        out_smp
);

   logic              vld_ff  [SQRT_STEPS];
   logic [REM_W-1:0]  rem_ff  [SQRT_STEPS];
   logic [ROOT_W-1:0] root_ff [SQRT_STEPS];
   logic [RAD_W-1:0]  rad_ff  [SQRT_STEPS];
   sample_type        smp_ff  [SQRT_STEPS];

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      logic              vld_prev;
      logic [REM_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [RAD_W-1:0]  rad_prev;
      sample_type        smp_prev;
      logic [REM_W-1:0]  rem_sh;
      logic [REM_W-1:0]  trial;
      logic              take;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;

      if (k == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = in_rad;
         assign smp_prev  = in_smp;
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
         assign smp_prev  = smp_ff[k-1];
      end

      always_comb begin
         rem_sh  = {rem_prev[REM_W-3:0], rad_prev[RAD_W-1 -: 2]};
         trial   = REM_W'({root_prev, 2'b01});
         take    = (rem_sh >= trial);
         rem_in  = take ? (rem_sh - trial) : rem_sh;
         root_in = {root_prev[ROOT_W-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (advance) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= rad_prev << 2;
            smp_ff[k]  <= smp_prev;
         end
      end
   end

   assign out_valid = vld_ff[SQRT_STEPS-1];
   assign out_root  = root_ff[SQRT_STEPS-1];
   assign out_smp   = smp_ff[SQRT_STEPS-1];

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (rem_ff[SQRT_STEPS-1] <= REM_W'({out_root, 1'b0})))
      else $error("square root remainder exceeds twice the root");

endmodule

`default_nettype wire

[hdl/atl_cordic.sv]
// Pipelined vectoring CORDIC that returns atan2(b, a) rounded to units of 2^-12 rad.
// Depends on atl_pkg.
`default_nettype none

module atl_cordic import atl_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  logic signed [CW-1:0]    in_a,
   input  logic signed [CW-1:0]    in_b,
   output logic                    out_valid,
   output logic signed [Q12_W-1:0] out_angle
);

   logic                 pre_vld_ff;
   logic                 pre_zero_ff;
   logic signed [CW-1:0] pre_a_ff;
   logic signed [CW-1:0] pre_b_ff;
   logic signed [AW-1:0] pre_ang_ff;
   logic                 pre_zero_in;
   logic signed [CW-1:0] pre_a_in;
   logic signed [CW-1:0] pre_b_in;
   logic signed [AW-1:0] pre_ang_in;

   logic                 vld_ff  [CORDIC_STAGES];
   logic                 zero_ff [CORDIC_STAGES];
   logic signed [CW-1:0] a_ff    [CORDIC_STAGES];
   logic signed [CW-1:0] b_ff    [CORDIC_STAGES];
   logic signed [AW-1:0] ang_ff  [CORDIC_STAGES];

   logic                    q_vld_ff;
   logic signed [Q12_W-1:0] q_ff;
   logic signed [Q12_W-1:0] q_in;
   logic signed [AW-1:0]    last_ang;
   logic [AW-1:0]           mag;
   logic [AW-1:0]           rnd;

   always_comb begin
      pre_zero_in = (in_a == '0) && (in_b == '0);
      if (in_a[CW-1]) begin
         if (!in_b[CW-1]) begin
            pre_a_in   = in_b;
            pre_b_in   = -in_a;
            pre_ang_in = HALF_PI_Q20;
         end else begin
            pre_a_in   = -in_b;
            pre_b_in   = in_a;
            pre_ang_in = -HALF_PI_Q20;
         end
      end else begin
         pre_a_in   = in_a;
         pre_b_in   = in_b;
         pre_ang_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_vld_ff <= 1'b0;
      end else if (advance) begin
         pre_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pre_zero_ff <= pre_zero_in;
         pre_a_ff    <= pre_a_in;
         pre_b_ff    <= pre_b_in;
         pre_ang_ff  <= pre_ang_in;
      end
   end

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_iter
      logic                 vld_prev;
      logic                 zero_prev;
      logic signed [CW-1:0] a_prev;
      logic signed [CW-1:0] b_prev;
      logic signed [AW-1:0] ang_prev;
      logic signed [CW-1:0] a_in;
      logic signed [CW-1:0] b_in;
      logic signed [AW-1:0] ang_in;

      if (k == 0) begin : g_first
         assign vld_prev  = pre_vld_ff;
         assign zero_prev = pre_zero_ff;
         assign a_prev    = pre_a_ff;
         assign b_prev    = pre_b_ff;
         assign ang_prev  = pre_ang_ff;
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign zero_prev = zero_ff[k-1];
         assign a_prev    = a_ff[k-1];
         assign b_prev    = b_ff[k-1];
         assign ang_prev  = ang_ff[k-1];
      end

      always_comb begin
         if (!b_prev[CW-1]) begin
            a_in   = a_prev + (b_prev >>> k);
            b_in   = b_prev - (a_prev >>> k);
            ang_in = ang_prev + atan_q20(k);
         end else begin
            a_in   = a_prev - (b_prev >>> k);
            b_in   = b_prev + (a_prev >>> k);
            ang_in = ang_prev - atan_q20(k);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (advance) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            zero_ff[k] <= zero_prev;
            a_ff[k]    <= a_in;
            b_ff[k]    <= b_in;
            ang_ff[k]  <= ang_in;
         end
      end
   end

   always_comb begin
      last_ang = ang_ff[CORDIC_STAGES-1];
      mag      = last_ang[AW-1] ? AW'(-last_ang) : AW'(last_ang);
      rnd      = (mag + ROUND_HALF) >> ROUND_SH;
      if (zero_ff[CORDIC_STAGES-1]) begin
         q_in = '0;
      end else if (last_ang[AW-1]) begin
         q_in = -$signed(rnd[Q12_W-1:0]);
      end else begin
         q_in = $signed(rnd[Q12_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_vld_ff <= 1'b0;
      end else if (advance) begin
         q_vld_ff <= vld_ff[CORDIC_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         q_ff <= q_in;
      end
   end

   assign out_valid = q_vld_ff;
   assign out_angle = q_ff;

endmodule

`default_nettype wire

[hdl/accelerometer_tilt_angles.sv]
// Each sample passes the product, sum, square root, CORDIC and output registers in order.
// Throughput: one beat per cycle unless a held result stalls it; the 32-step square root
// pipeline and the CORDIC stages each hold one sample per stage and all move together.
// While a result waits at the output, the pipeline moves until its last stage is full.
// Synchronous reset empties the pipeline and clears the three offsets to zero.
`default_nettype none

module accelerometer_tilt_angles import atl_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [IN_W-1:0]  req_accel_x,
   input  logic signed [IN_W-1:0]  req_accel_y,
   input  logic signed [IN_W-1:0]  req_accel_z,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [OUT_W-1:0] rsp_roll_angle,
   output logic signed [OFS_W-1:0] rsp_middle_angle,
   output logic signed [OUT_W-1:0] rsp_tilt_angle,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [OFS_W-1:0]        csr_wdata
);

   logic signed [OFS_W-1:0] roll_ofs_ff;
   logic signed [OFS_W-1:0] middle_ofs_ff;
   logic signed [OFS_W-1:0] tilt_ofs_ff;

   logic                     advance;
   logic                     out_free;

   logic                     prod_vld_ff;
   logic [2*IN_W-2:0]        yy_ff;
   logic [2*IN_W-2:0]        zz_ff;
   sample_type               prod_smp_ff;
   logic signed [2*IN_W-1:0] yy_full;
   logic signed [2*IN_W-1:0] zz_full;

   logic                     sum_vld_ff;
   logic [RAD_W-1:0]         sum_ff;
   sample_type               sum_smp_ff;

   logic                     sq_vld;
   logic [ROOT_W-1:0]        mag;
   sample_type               sq_smp;

   logic                     roll_vld;
   logic signed [Q12_W-1:0]  roll_q12;
   logic                     tilt_vld;
   logic signed [Q12_W-1:0]  tilt_q12;

   logic                     rsp_valid_ff;
   logic signed [OUT_W-1:0]  rsp_roll_ff;
   logic signed [OFS_W-1:0]  rsp_middle_ff;
   logic signed [OUT_W-1:0]  rsp_tilt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         roll_ofs_ff   <= '0;
         middle_ofs_ff <= '0;
         tilt_ofs_ff   <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ROLL_OFFSET:   roll_ofs_ff   <= $signed(csr_wdata);
            CSR_MIDDLE_OFFSET: middle_ofs_ff <= $signed(csr_wdata);
            CSR_TILT_OFFSET:   tilt_ofs_ff   <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = !tilt_vld || out_free;
   assign req_ready = advance;

   assign yy_full = req_accel_y * req_accel_y;
   assign zz_full = req_accel_z * req_accel_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         sum_vld_ff  <= 1'b0;
      end else if (advance) begin
         prod_vld_ff <= req_valid;
         sum_vld_ff  <= prod_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         yy_ff       <= yy_full[2*IN_W-2:0];
         zz_ff       <= zz_full[2*IN_W-2:0];
         prod_smp_ff <= '{x: req_accel_x, y: req_accel_y, z: req_accel_z};
         sum_ff      <= RAD_W'(yy_ff) + RAD_W'(zz_ff);
         sum_smp_ff  <= prod_smp_ff;
      end
   end

   atl_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (sum_vld_ff),
      .in_rad    (sum_ff),
      .in_smp    (sum_smp_ff),
      .out_valid (sq_vld),
      .out_root  (mag),
      .out_smp   (sq_smp)
   );

   atl_cordic u_roll (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (sq_vld),
      .in_a      (scale_in(sq_smp.z)),
      .in_b      (scale_in(sq_smp.y)),
      .out_valid (roll_vld),
      .out_angle (roll_q12)
   );

   atl_cordic u_tilt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (sq_vld),
      .in_a      (CW'(mag)),
      .in_b      (scale_in(sq_smp.x)),
      .out_valid (tilt_vld),
      .out_angle (tilt_q12)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= tilt_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_roll_ff   <= OUT_W'(roll_q12) + OUT_W'(roll_ofs_ff);
         rsp_middle_ff <= middle_ofs_ff;
         rsp_tilt_ff   <= OUT_W'(tilt_q12) + OUT_W'(tilt_ofs_ff);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_roll_angle   = rsp_roll_ff;
   assign rsp_middle_angle = rsp_middle_ff;
   assign rsp_tilt_angle   = rsp_tilt_ff;

   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      roll_vld == tilt_vld)
      else $error("roll and tilt pipelines out of step");

   a_stall_keeps_item: assert property (@(posedge clock) disable iff (reset)
      !req_ready |=> tilt_vld)
      else $error("stalled pipeline lost its last item");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat offered right after reset");

endmodule

`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for accelerometer_tilt_angles: it drives sample beats, predicts
// roll, middle and tilt angles with its own CORDIC model, and compares every result beat.
// Depends on atl_pkg and the accelerometer_tilt_angles RTL.
`timescale 1ns / 1ps

module tb import atl_pkg::*; ();

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = 2'd3;
   localparam longint QUARTER_TURN_Q20 = 1647099;
   localparam int MAX_STAGES = 24;
   localparam longint ATAN_STEP_Q20 [MAX_STAGES] = '{
      823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
      4096, 2048, 1024, 512, 256, 128, 64, 32,
      16, 8, 4, 2, 1, 0, 0, 0
   };

   typedef struct packed {
      logic signed [OUT_W-1:0] roll;
      logic signed [OFS_W-1:0] middle;
      logic signed [OUT_W-1:0] tilt;
   } angles_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic signed [IN_W-1:0]  req_accel_x = '0;
   logic signed [IN_W-1:0]  req_accel_y = '0;
   logic signed [IN_W-1:0]  req_accel_z = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [OUT_W-1:0] rsp_roll_angle;
   logic signed [OFS_W-1:0] rsp_middle_angle;
   logic signed [OUT_W-1:0] rsp_tilt_angle;
   logic                    csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [OFS_W-1:0]        csr_wdata = '0;

   logic signed [OFS_W-1:0] roll_ofs = '0;
   logic signed [OFS_W-1:0] mid_ofs = '0;
   logic signed [OFS_W-1:0] tilt_ofs = '0;

   sample_type queued_samples[$];
   angles_type pending_angles[$];
   sample_type next_sample;
   angles_type want;
   bit         steady = 1'b0;
   int         mismatches = 0;
   int         samples_sent = 0;
   int         results_checked = 0;
   int         settings_used = 1;

   accelerometer_tilt_angles DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_accel_x      (req_accel_x),
      .req_accel_y      (req_accel_y),
      .req_accel_z      (req_accel_z),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_roll_angle   (rsp_roll_angle),
      .rsp_middle_angle (rsp_middle_angle),
      .rsp_tilt_angle   (rsp_tilt_angle),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // Vectoring CORDIC, angle of (a, b) in units of 2^-20 rad.
   function automatic longint cordic_angle(longint b, longint a);
      longint ang;
      longint t;
      longint na;
      longint nb;
      ang = 0;
      if (a == 0 && b == 0) return 0;
      if (a < 0) begin
         if (b >= 0) begin
            t = a;
            a = b;
            b = -t;
            ang = QUARTER_TURN_Q20;
         end else begin
            t = a;
            a = -b;
            b = t;
            ang = -QUARTER_TURN_Q20;
         end
      end
      for (int i = 0; i < CORDIC_STAGES && i < MAX_STAGES; i++) begin
         if (b >= 0) begin
            na = a + (b >>> i);
            nb = b - (a >>> i);
            ang += ATAN_STEP_Q20[i];
         end else begin
            na = a - (b >>> i);
            nb = b + (a >>> i);
            ang -= ATAN_STEP_Q20[i];
         end
         a = na;
         b = nb;
      end
      return ang;
   endfunction

   function automatic longint round_q12(longint a);
      longint mag;
      longint r;
      mag = (a < 0) ? -a : a;
      r = (mag + 128) >>> 8;
      return (a < 0) ? -r : r;
   endfunction

   function automatic angles_type tilt_predict(sample_type s);
      longint x;
      longint y;
      longint z;
      longint roll;
      longint tilt;
      longint unsigned mag;
      angles_type r;
      x = longint'(s.x);
      y = longint'(s.y);
      z = longint'(s.z);
      mag = root_floor(longint'(y * y + z * z) << 32);
      roll = round_q12(cordic_angle(y * 65536, z * 65536)) + longint'(roll_ofs);
      tilt = round_q12(cordic_angle(x * 65536, longint'(mag))) + longint'(tilt_ofs);
      r.roll = OUT_W'(roll);
      r.middle = mid_ofs;
      r.tilt = OUT_W'(tilt);
      return r;
   endfunction

   function automatic logic [IN_W-1:0] edge_value();
      case ($urandom_range(5))
         0: return '0;
         1: return 16'h0001;
         2: return 16'hFFFF;
         3: return 16'h7FFF;
         4: return 16'h8000;
         default: return IN_W'($urandom);
      endcase
   endfunction

   function automatic sample_type random_sample();
      sample_type s;
      case ($urandom_range(3))
         0: begin
            s.x = IN_W'($urandom);
            s.y = IN_W'($urandom);
            s.z = IN_W'($urandom);
         end
         1: begin
            s.x = IN_W'($urandom_range(64)) - IN_W'(32);
            s.y = IN_W'($urandom_range(64)) - IN_W'(32);
            s.z = IN_W'($urandom_range(64)) - IN_W'(32);
         end
         2: begin
            s.x = IN_W'($urandom_range(33000)) - IN_W'(16500);
            s.y = IN_W'($urandom_range(33000)) - IN_W'(16500);
            s.z = IN_W'($urandom_range(33000)) - IN_W'(16500);
         end
         default: begin
            s.x = edge_value();
            s.y = edge_value();
            s.z = edge_value();
         end
      endcase
      return s;
   endfunction

   task automatic push_sample(int x, int y, int z);
      sample_type s;
      s.x = IN_W'(x);
      s.y = IN_W'(y);
      s.z = IN_W'(z);
      queued_samples.push_back(s);
   endtask

   task automatic push_random(int count);
      repeat (count) queued_samples.push_back(random_sample());
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, int value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= OFS_W'(value);
      case (idx)
         CSR_ROLL_OFFSET:   roll_ofs = OFS_W'(value);
         CSR_MIDDLE_OFFSET: mid_ofs = OFS_W'(value);
         CSR_TILT_OFFSET:   tilt_ofs = OFS_W'(value);
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_offsets(int roll, int middle, int tilt);
      write_csr(CSR_ROLL_OFFSET, roll);
      write_csr(CSR_MIDDLE_OFFSET, middle);
      write_csr(CSR_TILT_OFFSET, tilt);
      settings_used++;
   endtask

   // Sampled at the falling edge so that the driver's updates have settled.
   task automatic wait_drained();
      do @(negedge clock);
      while (queued_samples.size() != 0 || req_valid || pending_angles.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            pending_angles.push_back(tilt_predict('{req_accel_x, req_accel_y, req_accel_z}));
            samples_sent++;
         end
         if (!req_valid || req_ready) begin
            if (queued_samples.size() != 0 && (steady || $urandom_range(99) >= 12)) begin
               next_sample = queued_samples.pop_front();
               req_valid <= 1'b1;
               req_accel_x <= next_sample.x;
               req_accel_y <= next_sample.y;
               req_accel_z <= next_sample.z;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (pending_angles.size() == 0) begin
               mismatches++;
               $display("%0t: result beat with no sample outstanding: roll %0d middle %0d tilt %0d",
                        $time, rsp_roll_angle, rsp_middle_angle, rsp_tilt_angle);
            end else begin
               want = pending_angles.pop_front();
               if (rsp_roll_angle !== want.roll) begin
                  mismatches++;
                  $display("%0t: roll_angle expected %0d actual %0d",
                           $time, want.roll, rsp_roll_angle);
               end
               if (rsp_middle_angle !== want.middle) begin
                  mismatches++;
                  $display("%0t: middle_angle expected %0d actual %0d",
                           $time, want.middle, rsp_middle_angle);
               end
               if (rsp_tilt_angle !== want.tilt) begin
                  mismatches++;
                  $display("%0t: tilt_angle expected %0d actual %0d",
                           $time, want.tilt, rsp_tilt_angle);
               end
            end
         end
         rsp_ready <= steady || ($urandom_range(99) >= 12);
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Axis extremes, the zero vector, both quarter-turn cases and zero magnitude tilt.
      push_sample(0, 0, 0);
      push_sample(0, 0, 32767);
      push_sample(0, 0, -32768);
      push_sample(0, 32767, 0);
      push_sample(0, -32768, 0);
      push_sample(32767, 0, 0);
      push_sample(-32768, 0, 0);
      push_sample(32767, 32767, 32767);
      push_sample(-32768, -32768, -32768);
      push_sample(-32768, 32767, -32768);
      push_sample(32767, -32768, -32768);
      push_sample(0, 0, -1);
      push_sample(0, 1, -1);
      push_sample(0, -1, -1);
      push_sample(1, -1, 1);
      push_sample(100, 0, -5);
      push_sample(-1, 0, 0);
      push_sample(1, 0, 0);
      push_sample(16384, 0, 16384);
      push_sample(-16384, 11585, -11585);
      push_sample(0, 1, 0);
      push_sample(0, -1, 0);
      push_sample(32767, -32768, 32767);
      push_sample(-32768, 32767, 0);
      push_random(150);
      wait_drained();

      set_offsets(12868, -12868, -12868);
      push_random(170);
      wait_drained();

      steady = 1'b1;
      set_offsets(-12868, 12868, 12868);
      push_random(170);
      wait_drained();
      steady = 1'b0;

      set_offsets($urandom_range(25736) - 12868, $urandom_range(25736) - 12868,
                  $urandom_range(25736) - 12868);
      write_csr(CSR_SPARE_INDEX, $urandom_range(32767));
      push_random(170);
      wait_drained();

      set_offsets(0, 1, -1);
      push_random(170);
      wait_drained();

      repeat (60) @(posedge clock);
      $display("Checked %0d result beats against %0d sample beats.", results_checked,
               samples_sent);
      $display("Offset settings exercised: %0d, including both range extremes.",
               settings_used);
      if (mismatches == 0 && pending_angles.size() == 0) begin
         $display("PASS accelerometer_tilt_angles");
      end else begin
         $display("FAIL accelerometer_tilt_angles");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Timed out waiting for the pipeline to drain.");
      $display("FAIL accelerometer_tilt_angles");
      $finish;
   end

endmodule
